// ===== src/depthwise_conv2d_forward_unit_assert.svh =====
// ---------------------------------------------------------------------------
// depthwise conv2d forward unit assertion macros
// concurrent checks that compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef DEPTHWISE_CONV2D_FORWARD_UNIT_ASSERT_SVH
`define DEPTHWISE_CONV2D_FORWARD_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define DWC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwc check failed");
// next-cycle implication
`define DWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwc check failed");
`else
`define DWC_ASSERT_NOW(label, clk, rst, ante, cons)
`define DWC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/dwc_pkg.sv =====
// ---------------------------------------------------------------------------
// dwc_pkg
// shared codes, types and defaults of the depthwise conv2d forward unit
// ---------------------------------------------------------------------------
package dwc_pkg;

   // default sizes
   localparam int DEF_MAX_HEIGHT   = 256;
   localparam int DEF_MAX_WIDTH    = 256;
   localparam int DEF_MAX_CHANNELS = 64;
   localparam int DEF_MAX_KERNEL   = 7;
   localparam int DEF_WEIGHT_FRAC  = 14;

   // fixed widths
   localparam int POS_W = 14;   // signed window position
   localparam int ACC_W = 40;   // window accumulator
   localparam int K_W   = 3;    // kernel side counter

   // item actions
   localparam logic [1:0] ACT_WRITE_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_LOAD_WEIGHT  = 2'd1;
   localparam logic [1:0] ACT_LOAD_BIAS    = 2'd2;
   localparam logic [1:0] ACT_COMPUTE      = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_KSIDE     = 3'd0;
   localparam logic [2:0] CSR_STRIDE    = 3'd1;
   localparam logic [2:0] CSR_PAD       = 3'd2;
   localparam logic [2:0] CSR_IN_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_IN_WIDTH  = 3'd4;

   // register reset values
   localparam logic [2:0] RST_KSIDE     = 3'd3;
   localparam logic [2:0] RST_STRIDE    = 3'd1;
   localparam logic [2:0] RST_PAD       = 3'd1;
   localparam logic [8:0] RST_IN_HEIGHT = 9'd256;
   localparam logic [8:0] RST_IN_WIDTH  = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [8:0]         row;
      logic [8:0]         col;
      logic [5:0]         channel;
      logic [5:0]         tap;
      logic signed [15:0] sample;
      logic signed [15:0] coefficient;
      logic signed [31:0] bias_value;
   } req_type;

   typedef struct packed {
      logic ready;      // take an item
      logic start;      // latch a compute item
      logic step;       // issue one kernel tap
      logic wrap;       // this tap ends a kernel row
      logic load_out;   // move the finished sum into the output register
   } cmd_type;

   typedef struct packed {
      logic           compute;
      logic           ch_ok;
      logic           k_zero;
      logic [K_W-1:0] k;
      logic           out_busy;
   } status_type;

endpackage

// ===== src/dwc_req_if.sv =====
// ---------------------------------------------------------------------------
// dwc_req_if
// request channel: valid/ready handshake with the item payload
// ---------------------------------------------------------------------------
interface dwc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [8:0]         row;
   logic [8:0]         col;
   logic [5:0]         channel;
   logic [5:0]         tap;
   logic signed [15:0] sample;
   logic signed [15:0] coefficient;
   logic signed [31:0] bias_value;

   modport source (
      output valid, action, row, col, channel, tap, sample, coefficient, bias_value,
      input  ready
   );
   modport sink (
      input  valid, action, row, col, channel, tap, sample, coefficient, bias_value,
      output ready
   );
endinterface

// ===== src/dwc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// dwc_rsp_if
// response channel: valid/ready handshake with the result payload
// ---------------------------------------------------------------------------
interface dwc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic               saturated;

   modport source (
      output valid, result, saturated,
      input  ready
   );
   modport sink (
      input  valid, result, saturated,
      output ready
   );
endinterface

// ===== src/dwc_ram.sv =====
// ---------------------------------------------------------------------------
// dwc_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module dwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/dwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// dwc_ctrl
// sequencer: takes items, walks the kernel window, hands off the result
// ---------------------------------------------------------------------------
module dwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  dwc_pkg::status_type  status,
   output dwc_pkg::cmd_type     cmd
);

   dwc_pkg::ctrl_state_type state_ff, state_in;
   logic [dwc_pkg::K_W-1:0] kh_ff, kh_in;
   logic [dwc_pkg::K_W-1:0] kw_ff, kw_in;
   logic [dwc_pkg::K_W-1:0] k_last;
   logic                    row_end;
   logic                    win_end;

   assign k_last  = status.k - dwc_pkg::K_W'(1);
   assign row_end = (kw_ff == k_last);
   assign win_end = row_end && (kh_ff == k_last);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwc_pkg::ST_IDLE: begin
            if (req_valid && status.compute) begin
               // bad channel or empty kernel goes straight to the result
               if (status.ch_ok && !status.k_zero) begin
                  state_in = dwc_pkg::ST_WALK;
               end else begin
                  state_in = dwc_pkg::ST_FINISH;
               end
            end
         end
         dwc_pkg::ST_WALK: begin
            if (win_end) begin
               state_in = dwc_pkg::ST_DRAIN_A;
            end
         end
         dwc_pkg::ST_DRAIN_A: state_in = dwc_pkg::ST_DRAIN_B;
         dwc_pkg::ST_DRAIN_B: state_in = dwc_pkg::ST_FINISH;
         dwc_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = dwc_pkg::ST_IDLE;
            end
         end
         default: state_in = dwc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.ready    = (state_ff == dwc_pkg::ST_IDLE) && !reset;
      cmd.start    = (state_ff == dwc_pkg::ST_IDLE) && !reset && req_valid && status.compute;
      cmd.step     = (state_ff == dwc_pkg::ST_WALK);
      cmd.wrap     = (state_ff == dwc_pkg::ST_WALK) && row_end;
      cmd.load_out = (state_ff == dwc_pkg::ST_FINISH) && !status.out_busy;
   end

   // kernel row / column counters
   always_comb begin
      kh_in = kh_ff;
      kw_in = kw_ff;
      if (state_ff != dwc_pkg::ST_WALK) begin
         kh_in = '0;
         kw_in = '0;
      end else if (row_end) begin
         kw_in = '0;
         kh_in = kh_ff + dwc_pkg::K_W'(1);
      end else begin
         kw_in = kw_ff + dwc_pkg::K_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwc_pkg::ST_IDLE;
         kh_ff    <= '0;
         kw_ff    <= '0;
      end else begin
         state_ff <= state_in;
         kh_ff    <= kh_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

// ===== src/dwc_dp.sv =====
// ---------------------------------------------------------------------------
// dwc_dp
// datapath: registers, stores, window addressing, mac and output stage
// ---------------------------------------------------------------------------
module dwc_dp #(
   parameter int MAX_HEIGHT   = dwc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = dwc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = dwc_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = dwc_pkg::DEF_MAX_KERNEL,
   parameter int WEIGHT_FRAC  = dwc_pkg::DEF_WEIGHT_FRAC
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  dwc_pkg::req_type     req,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [8:0]           csr_data,
   input  dwc_pkg::cmd_type     cmd,
   output dwc_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_result,
   output logic                 rsp_saturated
);

   localparam int POS_W = dwc_pkg::POS_W;
   localparam int ACC_W = dwc_pkg::ACC_W;
   localparam int K_W   = dwc_pkg::K_W;
   localparam int HB    = $clog2(MAX_HEIGHT);
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int PLANE_DEPTH = 1 << (HB + CB);
   localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
   localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int WDEPTH = MAX_CHANNELS * TAPS;
   localparam int WA    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int BA    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W+1)'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W:0] SUM_MIN = (ACC_W+1)'(signed'(32'h8000_0000));

   // configuration registers
   logic [2:0] ksize_ff, stride_ff, pad_ff;
   logic [8:0] height_ff, width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff  <= dwc_pkg::RST_KSIDE;
         stride_ff <= dwc_pkg::RST_STRIDE;
         pad_ff    <= dwc_pkg::RST_PAD;
         height_ff <= dwc_pkg::RST_IN_HEIGHT;
         width_ff  <= dwc_pkg::RST_IN_WIDTH;
      end else if (csr_we) begin
         unique case (csr_index)
            dwc_pkg::CSR_KSIDE:     ksize_ff  <= csr_data[2:0];
            dwc_pkg::CSR_STRIDE:    stride_ff <= csr_data[2:0];
            dwc_pkg::CSR_PAD:       pad_ff    <= csr_data[2:0];
            dwc_pkg::CSR_IN_HEIGHT: height_ff <= csr_data;
            dwc_pkg::CSR_IN_WIDTH:  width_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective sizes, clipped to the store
   logic [K_W-1:0] k_eff;
   logic [8:0]     h_eff, w_eff;

   assign k_eff = (int'(ksize_ff) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : ksize_ff;
   assign h_eff = (int'(height_ff) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_ff;
   assign w_eff = (int'(width_ff) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_ff;

   // output register
   logic               rsp_vld_ff;
   logic signed [31:0] result_ff;
   logic               sat_ff;

   // item decode
   logic fire, ch_ok, tap_ok, in_store;
   logic [WA-1:0] wbase;

   assign fire     = req_valid && cmd.ready;
   assign ch_ok    = int'(req.channel) < MAX_CHANNELS;
   assign tap_ok   = int'(req.tap) < TAPS;
   assign in_store = (int'(req.row) < MAX_HEIGHT) && (int'(req.col) < MAX_WIDTH);
   assign wbase    = WA'(req.channel) * WA'(TAPS);

   assign status.compute  = (req.action == dwc_pkg::ACT_COMPUTE);
   assign status.ch_ok    = ch_ok;
   assign status.k_zero   = (k_eff == '0);
   assign status.k        = k_eff;
   assign status.out_busy = rsp_vld_ff && !rsp_ready;

   // window origin: row*stride - pad
   logic [11:0]             row_scaled, col_scaled;
   logic signed [POS_W-1:0] r0, c0;

   assign row_scaled = {3'b000, req.row} * {9'd0, stride_ff};
   assign col_scaled = {3'b000, req.col} * {9'd0, stride_ff};
   assign r0 = $signed(POS_W'(row_scaled)) - $signed(POS_W'(pad_ff));
   assign c0 = $signed(POS_W'(col_scaled)) - $signed(POS_W'(pad_ff));

   // window walk
   logic signed [POS_W-1:0] r_ff, c_ff, c0_ff;
   logic [TW-1:0]           tap_ff;
   logic [WA-1:0]           wbase_ff;
   logic                    ch_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         r_ff     <= r0;
         c_ff     <= c0;
         c0_ff    <= c0;
         tap_ff   <= '0;
         wbase_ff <= wbase;
      end else if (cmd.step) begin
         tap_ff <= tap_ff + TW'(1);
         if (cmd.wrap) begin
            r_ff <= r_ff + POS_W'(1);
            c_ff <= c0_ff;
         end else begin
            c_ff <= c_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ok_ff <= 1'b0;
      end else if (cmd.start) begin
         ch_ok_ff <= ch_ok;
      end
   end

   logic r_in, c_in;

   assign r_in = !r_ff[POS_W-1] && (r_ff[POS_W-2:0] < (POS_W-1)'(h_eff));
   assign c_in = !c_ff[POS_W-1] && (c_ff[POS_W-2:0] < (POS_W-1)'(w_eff));

   // stores
   logic                    plane_we, weight_we, bias_we;
   logic [HB+CB-1:0]        plane_waddr, plane_raddr;
   logic [WA-1:0]           weight_waddr, weight_raddr;
   logic signed [15:0]      sample_rd, weight_rd;
   logic signed [31:0]      bias_rd;

   assign plane_we     = fire && (req.action == dwc_pkg::ACT_WRITE_SAMPLE) && in_store;
   assign weight_we    = fire && (req.action == dwc_pkg::ACT_LOAD_WEIGHT) && ch_ok && tap_ok;
   assign bias_we      = fire && (req.action == dwc_pkg::ACT_LOAD_BIAS) && ch_ok;
   assign plane_waddr  = {HB'(req.row), CB'(req.col)};
   assign plane_raddr  = {r_ff[HB-1:0], c_ff[CB-1:0]};
   assign weight_waddr = wbase + WA'(req.tap);
   assign weight_raddr = wbase_ff + WA'(tap_ff);

   dwc_ram #(.WIDTH(16), .DEPTH(PLANE_DEPTH)) u_plane (
      .clock (clock),
      .we    (plane_we),
      .waddr (plane_waddr),
      .wdata (req.sample),
      .re    (cmd.step),
      .raddr (plane_raddr),
      .rdata (sample_rd)
   );

   dwc_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
      .clock (clock),
      .we    (weight_we),
      .waddr (weight_waddr),
      .wdata (req.coefficient),
      .re    (cmd.step),
      .raddr (weight_raddr),
      .rdata (weight_rd)
   );

   // bias read at start holds until the next compute item
   dwc_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_bias (
      .clock (clock),
      .we    (bias_we),
      .waddr (BA'(req.channel)),
      .wdata (req.bias_value),
      .re    (cmd.start),
      .raddr (BA'(req.channel)),
      .rdata (bias_rd)
   );

   // multiply-accumulate pipeline: read, product, accumulate
   logic                    tap_vld_ff, prod_vld_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         tap_vld_ff  <= cmd.step && r_in && c_in;
         prod_vld_ff <= tap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= sample_rd * weight_rd;
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // scale, bias, saturate; an out-of-range channel gives a zero result
   logic signed [ACC_W-1:0] scaled;
   logic signed [ACC_W:0]   total;
   logic signed [31:0]      result_in;
   logic                    sat_in;

   assign scaled = acc_ff >>> WEIGHT_FRAC;
   assign total  = (ACC_W+1)'(scaled) + (ACC_W+1)'(bias_rd);

   always_comb begin
      result_in = total[31:0];
      sat_in    = 1'b0;
      priority if (!ch_ok_ff) begin
         result_in = '0;
      end else if (total > SUM_MAX) begin
         result_in = 32'sh7FFF_FFFF;
         sat_in    = 1'b1;
      end else if (total < SUM_MIN) begin
         result_in = signed'(32'h8000_0000);
         sat_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= cmd.load_out || (rsp_vld_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_result    = result_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== src/depthwise_conv2d_forward_unit.sv =====
// ---------------------------------------------------------------------------
// depthwise_conv2d_forward_unit
// depthwise 2d convolution, one output sample per compute item
// ---------------------------------------------------------------------------
// Sample writes, weight loads and bias loads are accepted back to back. A
// compute item walks its k x k window one tap per cycle through the single
// read port of the plane memory, then drains through DRAIN_A and DRAIN_B
// and hands off in FINISH before the next item is accepted; a compute item
// with an out-of-range channel or a zero kernel size goes straight from IDLE
// to FINISH. If the previous result is still waiting in the output register
// the finished sum holds until it is taken. The stores come up undefined
// after reset and need no clearing.
module depthwise_conv2d_forward_unit #(
   parameter int MAX_HEIGHT   = dwc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = dwc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = dwc_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = dwc_pkg::DEF_MAX_KERNEL,
   parameter int WEIGHT_FRAC  = dwc_pkg::DEF_WEIGHT_FRAC
) (
   input  logic        clock,
   input  logic        reset,
   dwc_req_if.sink     req_port,
   dwc_rsp_if.source   rsp_port,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);

   `include "depthwise_conv2d_forward_unit_assert.svh"

   dwc_pkg::cmd_type    cmd;
   dwc_pkg::status_type status;
   dwc_pkg::req_type    req;

   assign req.action      = req_port.action;
   assign req.row         = req_port.row;
   assign req.col         = req_port.col;
   assign req.channel     = req_port.channel;
   assign req.tap         = req_port.tap;
   assign req.sample      = req_port.sample;
   assign req.coefficient = req_port.coefficient;
   assign req.bias_value  = req_port.bias_value;

   assign req_port.ready = cmd.ready;

   dwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .status    (status),
      .cmd       (cmd)
   );

   dwc_dp #(
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .WEIGHT_FRAC  (WEIGHT_FRAC)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req           (req),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_port.ready),
      .rsp_valid     (rsp_port.valid),
      .rsp_result    (rsp_port.result),
      .rsp_saturated (rsp_port.saturated)
   );

   // a pending result is never overwritten
   `DWC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !status.out_busy)
   // no item is taken while the window is being walked
   `DWC_ASSERT_NOW(a_walk_busy, clock, reset, cmd.step, !cmd.ready)
   // a compute item closes the input side on the next cycle
   `DWC_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start, !cmd.ready)
   // a handed-off sum shows up on the response side
   `DWC_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_out, rsp_port.valid)

endmodule
